### rtl/slst_pkg.sv
// ----------------------------------------------------------------------------
// slst_pkg
// Shared types and codes for the sequential list store: operation and status
// codes, fixed field widths and the result record passed to the output stage.
// ----------------------------------------------------------------------------
package slst_pkg;

  localparam int ENTRY_W = 32;
  localparam int OP_W    = 2;
  localparam int STAT_W  = 2;
  localparam int POS_W   = 6;
  localparam int OCC_W   = 7;

  localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd3;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [ENTRY_W-1:0] entry_value;
    logic [POS_W-1:0]   position;
    logic [OCC_W-1:0]   occupancy;
    logic               last;
  } slst_res_t;

endpackage

### rtl/sequential_list_store_core.sv
// ----------------------------------------------------------------------------
// sequential_list_store_core
// Ordered list of signed 32-bit values with append, delete-all-matches and
// in-order readout, backed by a single-port-pair entry RAM.
// ----------------------------------------------------------------------------
// One item is taken at a time; in_stall_o stays high until its work is done.
// Delete and readout walk the entry RAM one entry per cycle through its
// single registered read port (an empty list is not walked); readout
// pauses its walk while the output stage stalls. Op code 3 is dropped
// without a result. Results pass through an output register, so a new item
// is taken while a result waits there.
// ----------------------------------------------------------------------------
module sequential_list_store_core import slst_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [OP_W-1:0]           op_i,
  input  logic signed [ENTRY_W-1:0] value_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [STAT_W-1:0]         status_o,
  output logic signed [ENTRY_W-1:0] entry_value_o,
  output logic [POS_W-1:0]          position_o,
  output logic [OCC_W-1:0]          occupancy_o,
  output logic                      last_o
);

  slst_res_t res;
  logic      res_valid;
  logic      out_free;
  logic      out_valid_q, out_valid_d;
  slst_res_t out_q, out_d;

  slst_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .op_i        (op_i),
    .value_i     (value_i),
    .in_stall_o  (in_stall_o),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_take_i  (out_free)
  );

  // output register
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_d = (res_valid && out_free) || (out_valid_q && out_stall_i);
  assign out_d       = (res_valid && out_free) ? res : out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_q.status;
  assign entry_value_o = out_q.entry_value;
  assign position_o    = out_q.position;
  assign occupancy_o   = out_q.occupancy;
  assign last_o        = out_q.last;

endmodule

### rtl/slst_ram.sv
// ----------------------------------------------------------------------------
// slst_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds its data while the read enable is low.
// ----------------------------------------------------------------------------
module slst_ram #(
  parameter  int WIDTH = 32,
  parameter  int DEPTH = 64,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/slst_ctrl.sv
// ----------------------------------------------------------------------------
// slst_ctrl
// Sequencer for the list store: decodes one item, walks the entry RAM one
// entry per cycle unless stalled, through a single compare unit for delete
// compaction and readout, and presents result records to the output stage.
// ----------------------------------------------------------------------------
module slst_ctrl import slst_pkg::*; #(
  parameter  int DEPTH = 64,
  localparam int AW    = $clog2(DEPTH),
  localparam int CW    = $clog2(DEPTH + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic [OP_W-1:0]    op_i,
  input  logic [ENTRY_W-1:0] value_i,
  output logic               in_stall_o,
  output logic               res_valid_o,
  output slst_res_t          res_o,
  input  logic               res_take_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_DEL,
    S_READ,
    S_RESP
  } state_e;

  state_e             state_q, state_d;
  logic [OP_W-1:0]    op_q, op_d;
  logic [ENTRY_W-1:0] value_q, value_d;
  logic [CW-1:0]      count_q, count_d;
  logic [AW-1:0]      idx_q, idx_d;
  logic [AW-1:0]      wr_q, wr_d;
  logic [STAT_W-1:0]  rsp_status_q, rsp_status_d;
  logic [CW-1:0]      rsp_occ_q, rsp_occ_d;

  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic               mem_re;
  logic [AW-1:0]      mem_raddr;
  logic [ENTRY_W-1:0] mem_rdata;

  logic               keep;
  logic               last_entry;
  logic [CW-1:0]      kept_next;

  slst_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // shared compare unit
  assign keep       = (mem_rdata != value_q);
  assign last_entry = ((CW'(idx_q) + CW'(1)) == count_q);
  assign kept_next  = CW'(wr_q) + CW'(keep);

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    value_d      = value_q;
    count_d      = count_q;
    idx_d        = idx_q;
    wr_d         = wr_q;
    rsp_status_d = rsp_status_q;
    rsp_occ_d    = rsp_occ_q;
    mem_we       = 1'b0;
    mem_waddr    = wr_q;
    mem_wdata    = mem_rdata;
    mem_re       = 1'b0;
    mem_raddr    = idx_q + AW'(1);
    res_valid_o  = 1'b0;
    res_o        = '0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d    = op_i;
          value_d = value_i;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        case (op_q)
          OP_APPEND: begin
            state_d = S_RESP;
            if (count_q == CW'(DEPTH)) begin
              rsp_status_d = ST_FULL;
              rsp_occ_d    = count_q;
            end else begin
              mem_we       = 1'b1;
              mem_waddr    = count_q[AW-1:0];
              mem_wdata    = value_q;
              count_d      = count_q + CW'(1);
              rsp_status_d = ST_OK;
              rsp_occ_d    = count_q + CW'(1);
            end
          end
          OP_DELETE: begin
            if (count_q == '0) begin
              rsp_status_d = ST_NOT_FOUND;
              rsp_occ_d    = '0;
              state_d      = S_RESP;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = '0;
              idx_d     = '0;
              wr_d      = '0;
              state_d   = S_DEL;
            end
          end
          OP_READ: begin
            if (count_q == '0) begin
              rsp_status_d = ST_EMPTY;
              rsp_occ_d    = '0;
              state_d      = S_RESP;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = '0;
              idx_d     = '0;
              state_d   = S_READ;
            end
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      S_DEL: begin
        if (keep) begin
          mem_we    = 1'b1;
          mem_waddr = wr_q;
          mem_wdata = mem_rdata;
        end
        if (last_entry) begin
          state_d = S_RESP;
          if (kept_next == count_q) begin
            rsp_status_d = ST_NOT_FOUND;
            rsp_occ_d    = count_q;
          end else begin
            count_d      = kept_next;
            rsp_status_d = ST_OK;
            rsp_occ_d    = kept_next;
          end
        end else begin
          wr_d   = wr_q + AW'(keep);
          idx_d  = idx_q + AW'(1);
          mem_re = 1'b1;
        end
      end
      S_READ: begin
        res_valid_o       = 1'b1;
        res_o.status      = ST_OK;
        res_o.entry_value = mem_rdata;
        res_o.position    = POS_W'(idx_q);
        res_o.occupancy   = OCC_W'(count_q);
        res_o.last        = last_entry;
        if (res_take_i) begin
          if (last_entry) begin
            state_d = S_IDLE;
          end else begin
            idx_d  = idx_q + AW'(1);
            mem_re = 1'b1;
          end
        end
      end
      S_RESP: begin
        res_valid_o     = 1'b1;
        res_o.status    = rsp_status_q;
        res_o.occupancy = OCC_W'(rsp_occ_q);
        res_o.last      = 1'b1;
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      op_q         <= '0;
      value_q      <= '0;
      idx_q        <= '0;
      wr_q         <= '0;
      rsp_status_q <= ST_OK;
      rsp_occ_q    <= '0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      op_q         <= op_d;
      value_q      <= value_d;
      idx_q        <= idx_d;
      wr_q         <= wr_d;
      rsp_status_q <= rsp_status_d;
      rsp_occ_q    <= rsp_occ_d;
    end
  end

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("fill count beyond depth");

  a_compact_behind_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DEL) |-> (wr_q <= idx_q))
    else $error("compaction pointer ahead of scan");

  a_no_write_on_readout: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |-> !mem_we)
    else $error("store written during readout");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_take_i) |=> (res_valid_o && $stable(res_o)))
    else $error("pending result changed before taken");

endmodule

### sim/sequential_list_store_core_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sequential_list_store_core_checker
// Watches both channels of the list store, keeps its own copy of the list,
// predicts the results of every accepted item and compares each accepted
// result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module sequential_list_store_core_checker import slst_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_stall_i,
  input  logic [OP_W-1:0]           op_i,
  input  logic signed [ENTRY_W-1:0] value_i,
  input  logic                      out_valid_i,
  input  logic                      out_stall_i,
  input  logic [STAT_W-1:0]         status_i,
  input  logic signed [ENTRY_W-1:0] entry_value_i,
  input  logic [POS_W-1:0]          position_i,
  input  logic [OCC_W-1:0]          occupancy_i,
  input  logic                      last_i,
  output int                        fail_count_o,
  output int                        pending_o,
  output int                        result_count_o,
  output int                        full_count_o
);

  logic signed [ENTRY_W-1:0] list_mem [DEPTH];
  int unsigned               list_len;
  slst_res_t                 list_results_q [$];

  task automatic push_list_result(input logic [STAT_W-1:0] status,
                                  input logic [ENTRY_W-1:0] val,
                                  input int unsigned pos,
                                  input int unsigned occ,
                                  input logic last);
    slst_res_t res;
    res.status      = status;
    res.entry_value = val;
    res.position    = POS_W'(pos);
    res.occupancy   = OCC_W'(occ);
    res.last        = last;
    list_results_q.push_back(res);
  endtask

  task automatic apply_list_op(input logic [OP_W-1:0] op,
                               input logic signed [ENTRY_W-1:0] val);
    int unsigned kept;
    kept = 0;
    case (op)
      OP_APPEND: begin
        if (list_len >= DEPTH) begin
          push_list_result(ST_FULL, '0, 0, list_len, 1'b1);
        end else begin
          list_mem[list_len] = val;
          list_len++;
          push_list_result(ST_OK, '0, 0, list_len, 1'b1);
        end
      end
      OP_DELETE: begin
        for (int unsigned i = 0; i < list_len; i++) begin
          if (list_mem[i] != val) begin
            list_mem[kept] = list_mem[i];
            kept++;
          end
        end
        if (kept == list_len) begin
          push_list_result(ST_NOT_FOUND, '0, 0, list_len, 1'b1);
        end else begin
          list_len = kept;
          push_list_result(ST_OK, '0, 0, list_len, 1'b1);
        end
      end
      OP_READ: begin
        if (list_len == 0) begin
          push_list_result(ST_EMPTY, '0, 0, 0, 1'b1);
        end else begin
          for (int unsigned i = 0; i < list_len; i++) begin
            push_list_result(ST_OK, list_mem[i], i, list_len, (i + 1 == list_len));
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_list_result();
    slst_res_t want;
    result_count_o++;
    if (status_i == ST_FULL) full_count_o++;
    if (list_results_q.size() == 0) begin
      $error("unexpected result: status %0d entry_value %0d position %0d occupancy %0d last %0d",
             status_i, entry_value_i, position_i, occupancy_i, last_i);
      fail_count_o++;
    end else begin
      want = list_results_q.pop_front();
      if (status_i !== want.status) begin
        $error("status mismatch: expected %0d, got %0d", want.status, status_i);
        fail_count_o++;
      end
      if (entry_value_i !== $signed(want.entry_value)) begin
        $error("entry_value mismatch: expected %0d, got %0d",
               $signed(want.entry_value), entry_value_i);
        fail_count_o++;
      end
      if (position_i !== want.position) begin
        $error("position mismatch: expected %0d, got %0d", want.position, position_i);
        fail_count_o++;
      end
      if (occupancy_i !== want.occupancy) begin
        $error("occupancy mismatch: expected %0d, got %0d", want.occupancy, occupancy_i);
        fail_count_o++;
      end
      if (last_i !== want.last) begin
        $error("last mismatch: expected %0d, got %0d", want.last, last_i);
        fail_count_o++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      list_len = 0;
      list_results_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) check_list_result();
      if (in_valid_i && !in_stall_i) apply_list_op(op_i, value_i);
    end
    pending_o = list_results_q.size();
  end

endmodule

### sim/sequential_list_store_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sequential_list_store_core_tb
// Drives appends, deletes, readouts and the unused op into the list store
// with random gaps and output stalls, fills the store to capacity, holds
// the output off for a long stretch, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module sequential_list_store_core_tb;
  import slst_pkg::*;

  localparam int              DEPTH       = 64;
  localparam int              HOLD_CYCLES = 300;
  localparam int              ITEM_TARGET = 310;
  localparam logic [OP_W-1:0] OP_UNUSED   = 2'd3;

  logic                      clk_i       = 1'b0;
  logic                      rst_ni      = 1'b0;
  logic                      in_valid_i  = 1'b0;
  logic                      in_stall_o;
  logic [OP_W-1:0]           op_i        = OP_APPEND;
  logic signed [ENTRY_W-1:0] value_i     = '0;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic [STAT_W-1:0]         status_o;
  logic signed [ENTRY_W-1:0] entry_value_o;
  logic [POS_W-1:0]          position_o;
  logic [OCC_W-1:0]          occupancy_o;
  logic                      last_o;

  int fail_count;
  int pending;
  int result_count;
  int full_count;
  int items_sent = 0;
  int hold_req   = 0;
  int hold_done  = 0;
  bit tx_burst   = 1'b0;
  bit rx_burst   = 1'b0;

  logic signed [ENTRY_W-1:0] value_pool [8];

  always #4 clk_i = ~clk_i;

  sequential_list_store_core #(.DEPTH(DEPTH)) dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .op_i, .value_i,
    .out_valid_o, .out_stall_i, .status_o, .entry_value_o, .position_o,
    .occupancy_o, .last_o
  );

  sequential_list_store_core_checker #(.DEPTH(DEPTH)) u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .op_i, .value_i,
    .out_valid_i(out_valid_o), .out_stall_i, .status_i(status_o),
    .entry_value_i(entry_value_o), .position_i(position_o),
    .occupancy_i(occupancy_o), .last_i(last_o),
    .fail_count_o(fail_count), .pending_o(pending),
    .result_count_o(result_count), .full_count_o(full_count)
  );

  task automatic send_item(input logic [OP_W-1:0] op, input logic signed [ENTRY_W-1:0] val);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    value_i    <= val;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    wait (pending == 0);
    @(posedge clk_i);
  endtask

  task automatic refill_pool();
    foreach (value_pool[i]) value_pool[i] = $urandom;
  endtask

  task automatic send_mixed_item();
    int pick;
    pick = $urandom_range(0, 99);
    if (items_sent % 32 == 0) begin
      tx_burst = ($urandom_range(0, 3) == 0);
      rx_burst = ($urandom_range(0, 3) == 0);
    end
    if (pick < 50) begin
      if ($urandom_range(0, 9) < 7) send_item(OP_APPEND, value_pool[$urandom_range(0, 7)]);
      else send_item(OP_APPEND, $urandom);
    end else if (pick < 72) begin
      send_item(OP_DELETE, value_pool[$urandom_range(0, 7)]);
    end else if (pick < 77) begin
      send_item(OP_DELETE, $urandom);
    end else if (pick < 93) begin
      send_item(OP_READ, $urandom);
    end else begin
      send_item(OP_UNUSED, $urandom);
    end
  endtask

  // output side: random stalls per item, plus one long hold-off on request
  initial begin : result_sink
    int gap;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req != hold_done) begin
        hold_done++;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        gap = rx_burst ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
          out_stall_i <= 1'b1;
          repeat (gap) @(posedge clk_i);
        end
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin : reset_gen
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin : run_limit
    #8_000_000;
    $display("sequential_list_store_core verification failed");
    $finish;
  end

  initial begin : stimulus
    wait (rst_ni);
    @(posedge clk_i);

    // empty list corners
    send_item(OP_READ, 32'sd0);
    send_item(OP_DELETE, 32'sd0);
    send_item(OP_UNUSED, -32'sd1);
    // value extremes, -1 as ordinary data
    send_item(OP_APPEND, 32'sh8000_0000);
    send_item(OP_APPEND, 32'sh7FFF_FFFF);
    send_item(OP_APPEND, 32'sd0);
    send_item(OP_APPEND, -32'sd1);
    send_item(OP_APPEND, 32'sh5555_5555);
    send_item(OP_APPEND, 32'shAAAA_AAAA);
    send_item(OP_APPEND, -32'sd1);
    send_item(OP_READ, 32'sd0);
    send_item(OP_DELETE, -32'sd1);
    send_item(OP_DELETE, 32'sd12345);
    send_item(OP_UNUSED, 32'sd0);
    send_item(OP_READ, 32'sh7FFF_FFFF);
    send_item(OP_DELETE, 32'sh8000_0000);
    send_item(OP_DELETE, 32'sd0);
    send_item(OP_DELETE, 32'sh7FFF_FFFF);
    send_item(OP_APPEND, 32'sd1);
    send_item(OP_DELETE, 32'sh5555_5555);
    send_item(OP_DELETE, 32'shAAAA_AAAA);
    send_item(OP_DELETE, 32'sd1);
    send_item(OP_READ, 32'sd0);
    drain_results();

    refill_pool();
    value_pool[0] = -32'sd1;
    repeat (80) send_mixed_item();

    // fill to capacity and keep appending past full
    tx_burst = 1'b0;
    repeat (70) send_item(OP_APPEND, value_pool[$urandom_range(0, 7)]);
    hold_req++;
    send_item(OP_READ, $urandom);
    repeat (6) send_item(OP_DELETE, value_pool[$urandom_range(0, 7)]);
    drain_results();

    refill_pool();
    while (items_sent < ITEM_TARGET) send_mixed_item();

    drain_results();
    repeat (DEPTH + 8) @(posedge clk_i);

    $display("covered %0d items (append, delete, readout, unused op), %0d results checked",
             items_sent, result_count);
    $display("store hit capacity %0d times; output held off once for %0d cycles",
             full_count, HOLD_CYCLES);
    if (fail_count == 0 && pending == 0) begin
      $display("sequential_list_store_core verification clean");
    end else begin
      $display("sequential_list_store_core verification failed");
    end
    $finish;
  end

endmodule

### files.f
rtl/slst_pkg.sv
rtl/slst_ram.sv
rtl/slst_ctrl.sv
rtl/sequential_list_store_core.sv
sim/sequential_list_store_core_checker.sv
sim/sequential_list_store_core_tb.sv
